// ===== rtl/core/spq_pkg.sv =====
// Shared types, codes and constants of the sorted priority queue.
`default_nettype none
package spq_pkg;

  // Default number of queue entries
  localparam int unsigned SPQ_DEPTH = 16;

  // Item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Input word
  typedef struct packed {
    logic               kind;
    logic signed [31:0] value;
    logic        [7:0]  priority_req;
  } spq_in_t;

  // Result word
  typedef struct packed {
    logic signed [31:0] popped_value;
    logic        [1:0]  status;
    logic        [4:0]  entry_count;
  } spq_out_t;

  // Datapath operation selected by the controller
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2,
    OP_REJECT = 2'd3
  } spq_op_e;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    spq_op_e op;
  } spq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_pop;
    logic empty;
    logic full;
  } spq_stat_t;

  // Controller states, one-hot
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } spq_state_e;

endpackage
`default_nettype wire

// ===== rtl/core/spq_ctrl.sv =====
// Controller state machine of the sorted priority queue.
`default_nettype none
module spq_ctrl
  import spq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire spq_stat_t stat_i,
  output spq_cmd_t       cmd_o
);

  spq_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Take a word in idle once the result slot is free or draining
  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  // Next state, commands and result valid
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.load  = 1'b0;
    cmd_o.op    = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.req_pop) begin
          cmd_o.op = stat_i.empty ? OP_REJECT : OP_POP;
        end else begin
          cmd_o.op = stat_i.full ? OP_REJECT : OP_INSERT;
        end
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/spq_datapath.sv =====
// Datapath of the sorted priority queue: request register, sorted cell row, result register.
`default_nettype none
module spq_datapath
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = SPQ_DEPTH
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire spq_in_t  in_data_i,
  input  wire spq_cmd_t cmd_i,
  output spq_stat_t     stat_o,
  output spq_out_t      out_data_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  spq_in_t            req_q;
  spq_out_t           result_q, result_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  logic signed [31:0] val_q [DEPTH];
  logic        [7:0]  pri_q [DEPTH];
  logic signed [31:0] ins_val [DEPTH];
  logic        [7:0]  ins_pri [DEPTH];
  logic signed [31:0] pop_val [DEPTH];
  logic        [7:0]  pop_pri [DEPTH];
  logic [DEPTH-1:0]   lt;

  // Status for the controller
  assign stat_o.req_pop = (req_q.kind == KIND_POP);
  assign stat_o.empty   = (cnt_q == '0);
  assign stat_o.full    = (cnt_q == CNT_W'(DEPTH));

  // Per-cell compare and neighbor selection
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] CellIdx = CNT_W'(i);
    // cell holds a live entry that goes ahead of the new one
    assign lt[i] = (CellIdx < cnt_q) && (pri_q[i] < req_q.priority_req);

    if (i == 0) begin : g_head
      assign ins_val[i] = lt[i] ? val_q[i] : req_q.value;
      assign ins_pri[i] = lt[i] ? pri_q[i] : req_q.priority_req;
    end else begin : g_body
      always_comb begin
        if (lt[i]) begin
          ins_val[i] = val_q[i];
          ins_pri[i] = pri_q[i];
        end else if (lt[i-1]) begin
          ins_val[i] = req_q.value;
          ins_pri[i] = req_q.priority_req;
        end else begin
          ins_val[i] = val_q[i-1];
          ins_pri[i] = pri_q[i-1];
        end
      end
    end

    if (i == DEPTH - 1) begin : g_tail
      assign pop_val[i] = val_q[i];
      assign pop_pri[i] = pri_q[i];
    end else begin : g_shift
      assign pop_val[i] = val_q[i+1];
      assign pop_pri[i] = pri_q[i+1];
    end
  end

  // Count and result of the executed operation
  always_comb begin
    cnt_d                 = cnt_q;
    result_d              = result_q;
    result_d.popped_value = '0;
    result_d.status       = ST_OK;
    case (cmd_i.op)
      OP_INSERT: cnt_d = cnt_q + 1'b1;
      OP_POP: begin
        cnt_d                 = cnt_q - 1'b1;
        result_d.popped_value = val_q[0];
      end
      OP_REJECT: result_d.status = stat_o.req_pop ? ST_EMPTY : ST_FULL;
      default: result_d = result_q;
    endcase
    if (cmd_i.op != OP_NONE) begin
      result_d.entry_count = 5'(cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i;
    end
    result_q <= result_d;
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd_i.op == OP_INSERT) begin
        val_q[i] <= ins_val[i];
        pri_q[i] <= ins_pri[i];
      end else if (cmd_i.op == OP_POP) begin
        val_q[i] <= pop_val[i];
        pri_q[i] <= pop_pri[i];
      end
    end
  end

  assign out_data_o = result_q;

endmodule
`default_nettype wire

// ===== rtl/core/sorted_priority_queue_core.sv =====
// Top level of the sorted priority queue: controller, datapath and checks.
`default_nettype none
// Sorted priority queue of DEPTH entries (32-bit data, 8-bit priority, lower served
// first). An insert lands after all entries of strictly lower priority, ahead of equal
// ones; a pop returns the head. Every accepted word gives one result word with the
// popped data (zero unless a pop succeeded), a status (ok, pop on empty, insert dropped
// because full) and the entry count after the item, modulo 32. An item has an accept
// cycle, then an execute cycle in which every cell of the row compares and shifts at
// once. The result sits in an output register, and the next word is taken in the cycle
// after execution if that register is free or being read out.
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = SPQ_DEPTH
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire spq_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output spq_out_t     out_data_o
);

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

  // One word in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("word accepted during execution");

  // A result follows each accepted word
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> ##1 out_valid_o)
    else $error("result missing after execution");

  // Pop on empty leaves the queue empty
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_EMPTY) |-> (out_data_o.entry_count == 5'd0))
    else $error("empty status with nonzero count");

  // Dropped insert only at full occupancy
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_FULL) |-> (out_data_o.entry_count == 5'(DEPTH)))
    else $error("full status below full count");

endmodule
`default_nettype wire
